// ===== hw/rtl/cbs_pkg.sv =====
// ----------------------------------------------------------------------------
// cbs_pkg
// types and constants shared by the b-spline segmenter modules
// ----------------------------------------------------------------------------
package cbs_pkg;

  localparam int MAX_SEGMENTS = 64;
  localparam int SEG_W        = 7;
  localparam int CFG_IDX_W    = 2;

  localparam logic [CFG_IDX_W-1:0] CFG_SEGMENTS_PER_SPAN = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LINE_COLOR        = 2'd1;
  // index with no register behind it, writes are dropped
  localparam logic [CFG_IDX_W-1:0] CFG_RESERVED          = 2'd3;

  typedef struct packed {
    logic signed [15:0] point_x;
    logic signed [15:0] point_y;
    logic               new_curve;
  } in_item_t;

  typedef struct packed {
    logic signed [15:0] start_x;
    logic signed [15:0] start_y;
    logic signed [15:0] end_x;
    logic signed [15:0] end_y;
    logic [31:0]        seg_color;
    logic               last_segment;
  } out_item_t;

  typedef enum logic [3:0] {
    OP_NONE, OP_LOAD, OP_N2, OP_N3, OP_SQ, OP_CUBE, OP_WGT,
    OP_MAC, OP_DIVINIT, OP_DIV, OP_FINISH
  } dp_op_t;

  typedef struct packed {
    dp_op_t     op;
    logic [1:0] k;
  } dp_cmd_t;

  typedef struct packed {
    logic emit_span;
    logic j_zero;
    logic j_last;
    logic out_busy;
  } dp_status_t;

endpackage

// ===== hw/rtl/cbs_ctrl.sv =====
// ----------------------------------------------------------------------------
// cbs_ctrl
// sequencer for span setup, weights, mac, division and segment output
// ----------------------------------------------------------------------------
module cbs_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  cbs_pkg::dp_status_t status,
  output cbs_pkg::dp_cmd_t    cmd
);

  typedef enum logic [3:0] {
    S_IDLE, S_N2, S_N3, S_SQ, S_CUBE, S_WGT, S_MAC, S_DINIT, S_DIV, S_FIN
  } state_t;

  state_t     state_r;
  logic [3:0] cnt_r;
  logic       accept;

  assign in_ready = (state_r == S_IDLE);
  assign accept   = in_valid && in_ready;

  always_comb begin
    cmd.k  = cnt_r[1:0];
    cmd.op = cbs_pkg::OP_NONE;
    unique case (state_r)
      S_IDLE:  cmd.op = accept ? cbs_pkg::OP_LOAD : cbs_pkg::OP_NONE;
      S_N2:    cmd.op = cbs_pkg::OP_N2;
      S_N3:    cmd.op = cbs_pkg::OP_N3;
      S_SQ:    cmd.op = cbs_pkg::OP_SQ;
      S_CUBE:  cmd.op = cbs_pkg::OP_CUBE;
      S_WGT:   cmd.op = cbs_pkg::OP_WGT;
      S_MAC:   cmd.op = cbs_pkg::OP_MAC;
      S_DINIT: cmd.op = cbs_pkg::OP_DIVINIT;
      S_DIV:   cmd.op = cbs_pkg::OP_DIV;
      S_FIN:   cmd.op = (status.j_zero || !status.out_busy) ? cbs_pkg::OP_FINISH
                                                            : cbs_pkg::OP_NONE;
      default: cmd.op = cbs_pkg::OP_NONE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= '0;
    end else begin
      unique case (state_r)
        S_IDLE:  if (accept && status.emit_span) state_r <= S_N2;
        S_N2:    state_r <= S_N3;
        S_N3:    state_r <= S_SQ;
        S_SQ:    state_r <= S_CUBE;
        S_CUBE:  state_r <= S_WGT;
        S_WGT: begin
          state_r <= S_MAC;
          cnt_r   <= '0;
        end
        S_MAC: begin
          cnt_r <= cnt_r + 4'd1;
          if (cnt_r == 4'd3) state_r <= S_DINIT;
        end
        S_DINIT: begin
          state_r <= S_DIV;
          cnt_r   <= '0;
        end
        S_DIV: begin
          cnt_r <= cnt_r + 4'd1;
          if (cnt_r == 4'd15) state_r <= S_FIN;
        end
        S_FIN: begin
          if (status.j_zero || !status.out_busy) begin
            state_r <= status.j_last ? S_IDLE : S_SQ;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule

// ===== hw/rtl/cbs_datapath.sv =====
// ----------------------------------------------------------------------------
// cbs_datapath
// point window, basis weights, x/y mac, restoring dividers, output register
// ----------------------------------------------------------------------------
module cbs_datapath (
  input  logic                                clk,
  input  logic                                rst_n,
  input  cbs_pkg::in_item_t                   in_data,
  input  logic                                cfg_valid,
  input  logic [cbs_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [31:0]                         cfg_data,
  input  cbs_pkg::dp_cmd_t                    cmd,
  output cbs_pkg::dp_status_t                 status,
  output logic                                out_valid,
  input  logic                                out_ready,
  output cbs_pkg::out_item_t                  out_data
);

  localparam int SW = cbs_pkg::SEG_W;

  logic [SW-1:0]      segs_r;
  logic [31:0]        color_r;
  logic [31:0]        win_r [3];
  logic [1:0]         held_r;
  logic signed [15:0] px_r [4];
  logic signed [15:0] py_r [4];
  logic [SW-1:0]      n_r, j_r;
  logic [12:0]        n2_r, j2_r, m2_r;
  logic [18:0]        n3_r, j3_r, m3_r, nj2_r, n2j_r;
  logic [22:0]        d_r;
  logic [23:0]        w_r [4];
  logic signed [39:0] accx_r, accy_r;
  logic [22:0]        remx_r, remy_r;
  logic [15:0]        quox_r, quoy_r;
  logic               negx_r, negy_r;
  logic signed [15:0] sx_r, sy_r;
  logic               out_valid_r;
  cbs_pkg::out_item_t out_r;

  logic [1:0]         h_eff;
  logic [SW-1:0]      n_clamp, m_val;
  logic [23:0]        w1_nxt, w2_nxt;
  logic signed [39:0] prodx, prody;
  logic [38:0]        magx, magy;
  logic [23:0]        trialx, trialy;
  logic signed [15:0] qx, qy;

  assign h_eff = in_data.new_curve ? 2'd0 : held_r;
  assign status.emit_span = (h_eff == 2'd3);
  assign status.j_zero    = (j_r == '0);
  assign status.j_last    = (j_r == n_r);
  assign status.out_busy  = out_valid_r && !out_ready;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  always_comb begin
    if (segs_r == '0) n_clamp = SW'(1);
    else if (segs_r > SW'(cbs_pkg::MAX_SEGMENTS)) n_clamp = SW'(cbs_pkg::MAX_SEGMENTS);
    else n_clamp = segs_r;
  end

  assign m_val  = n_r - j_r;
  assign w1_nxt = {n3_r, 2'b00} - ({nj2_r, 2'b00} + {nj2_r, 1'b0}) + ({j3_r, 1'b0} + j3_r);
  assign w2_nxt = 24'(n3_r) + ({n2j_r, 1'b0} + n2j_r) + ({nj2_r, 1'b0} + nj2_r)
                  - ({j3_r, 1'b0} + j3_r);
  assign prodx  = 40'($signed({1'b0, w_r[cmd.k]}) * px_r[cmd.k]);
  assign prody  = 40'($signed({1'b0, w_r[cmd.k]}) * py_r[cmd.k]);
  assign magx   = accx_r[39] ? 39'(-accx_r) : accx_r[38:0];
  assign magy   = accy_r[39] ? 39'(-accy_r) : accy_r[38:0];
  assign trialx = {remx_r, quox_r[15]};
  assign trialy = {remy_r, quoy_r[15]};
  assign qx     = negx_r ? -$signed(quox_r) : $signed(quox_r);
  assign qy     = negy_r ? -$signed(quoy_r) : $signed(quoy_r);

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      segs_r      <= SW'(16);
      color_r     <= '0;
      held_r      <= '0;
      win_r[0]    <= '0;
      win_r[1]    <= '0;
      win_r[2]    <= '0;
      out_valid_r <= 1'b0;
      j_r         <= '0;
      n_r         <= SW'(1);
    end else begin
      if (cfg_valid) begin
        case (cfg_index)
          cbs_pkg::CFG_SEGMENTS_PER_SPAN: segs_r  <= cfg_data[SW-1:0];
          cbs_pkg::CFG_LINE_COLOR:        color_r <= cfg_data;
          default: ;
        endcase
      end
      if (cmd.op == cbs_pkg::OP_FINISH && j_r != '0) out_valid_r <= 1'b1;
      else if (out_valid_r && out_ready) out_valid_r <= 1'b0;
      if (cmd.op == cbs_pkg::OP_LOAD) begin
        if (h_eff != 2'd3) begin
          win_r[h_eff] <= {in_data.point_x, in_data.point_y};
          held_r       <= h_eff + 2'd1;
        end else begin
          win_r[0] <= win_r[1];
          win_r[1] <= win_r[2];
          win_r[2] <= {in_data.point_x, in_data.point_y};
          held_r   <= 2'd3;
          j_r      <= '0;
          n_r      <= n_clamp;
        end
      end
      if (cmd.op == cbs_pkg::OP_FINISH) begin
        j_r <= j_r + SW'(1);
      end
    end
  end

  // arithmetic payload
  always_ff @(posedge clk) begin
    case (cmd.op)
      cbs_pkg::OP_LOAD: begin
        if (h_eff == 2'd3) begin
          for (int i = 0; i < 3; i++) begin
            px_r[i] <= win_r[i][31:16];
            py_r[i] <= win_r[i][15:0];
          end
          px_r[3] <= in_data.point_x;
          py_r[3] <= in_data.point_y;
        end
      end
      cbs_pkg::OP_N2: n2_r <= 13'(n_r * n_r);
      cbs_pkg::OP_N3: n3_r <= 19'(n2_r * n_r);
      cbs_pkg::OP_SQ: begin
        j2_r <= 13'(j_r * j_r);
        m2_r <= 13'(m_val * m_val);
        d_r  <= 23'({n3_r, 2'b00}) + 23'({n3_r, 1'b0});
      end
      cbs_pkg::OP_CUBE: begin
        j3_r  <= 19'(j2_r * j_r);
        m3_r  <= 19'(m2_r * m_val);
        nj2_r <= 19'(j2_r * n_r);
        n2j_r <= 19'(n2_r * j_r);
      end
      cbs_pkg::OP_WGT: begin
        w_r[0] <= 24'(m3_r);
        w_r[1] <= w1_nxt;
        w_r[2] <= w2_nxt;
        w_r[3] <= 24'(j3_r);
        accx_r <= '0;
        accy_r <= '0;
      end
      cbs_pkg::OP_MAC: begin
        accx_r <= accx_r + prodx;
        accy_r <= accy_r + prody;
      end
      cbs_pkg::OP_DIVINIT: begin
        negx_r <= accx_r[39];
        negy_r <= accy_r[39];
        remx_r <= 23'(magx >> 16);
        remy_r <= 23'(magy >> 16);
        quox_r <= magx[15:0];
        quoy_r <= magy[15:0];
      end
      cbs_pkg::OP_DIV: begin
        if (trialx >= 24'(d_r)) begin
          remx_r <= 23'(trialx - 24'(d_r));
          quox_r <= {quox_r[14:0], 1'b1};
        end else begin
          remx_r <= trialx[22:0];
          quox_r <= {quox_r[14:0], 1'b0};
        end
        if (trialy >= 24'(d_r)) begin
          remy_r <= 23'(trialy - 24'(d_r));
          quoy_r <= {quoy_r[14:0], 1'b1};
        end else begin
          remy_r <= trialy[22:0];
          quoy_r <= {quoy_r[14:0], 1'b0};
        end
      end
      cbs_pkg::OP_FINISH: begin
        sx_r <= qx;
        sy_r <= qy;
        if (j_r != '0) begin
          out_r.start_x      <= sx_r;
          out_r.start_y      <= sy_r;
          out_r.end_x        <= qx;
          out_r.end_y        <= qy;
          out_r.seg_color    <= color_r;
          out_r.last_segment <= (j_r == n_r);
        end
      end
      default: ;
    endcase
  end

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.op == cbs_pkg::OP_FINISH && j_r != '0) |-> !(out_valid_r && !out_ready))
    else $error("segment written over a pending transfer");

  a_j_bound: assert property (@(posedge clk) disable iff (!rst_n)
    j_r <= n_r + SW'(1))
    else $error("segment index past span count");

  a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.op == cbs_pkg::OP_DIV) |=> (remx_r < d_r) && (remy_r < d_r))
    else $error("divider remainder out of range");

  a_n_range: assert property (@(posedge clk) disable iff (!rst_n)
    (n_r != '0) && (n_r <= SW'(cbs_pkg::MAX_SEGMENTS)))
    else $error("span count out of range");

endmodule

// ===== hw/rtl/cubic_bspline_segmenter_top.sv =====
// ----------------------------------------------------------------------------
// cubic_bspline_segmenter_top
// uniform cubic b-spline span to line segment generator
// ----------------------------------------------------------------------------
//  channel | direction | handshake             | payload
//  in_     | input     | in_valid / in_ready   | cbs_pkg::in_item_t
//  out_    | output    | out_valid / out_ready | cbs_pkg::out_item_t
//  cfg_    | input     | cfg_valid / cfg_ready | cfg_index, cfg_data
//
// a point that only fills the window is taken while the sequencer stays idle
// a span point runs span setup (n^2, n^3), then for each spline sample (n+1
//   samples) square, cube, weights, 4-step mac, 16-step restoring dividers
// synchronous active-low reset: window empty, 16 segments, color zero
// a stalled output holds the sequencer before the next segment is written
// config transfers are always taken
// ----------------------------------------------------------------------------
module cubic_bspline_segmenter_top (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  cbs_pkg::in_item_t             in_data,
  output logic                          out_valid,
  input  logic                          out_ready,
  output cbs_pkg::out_item_t            out_data,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [cbs_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]                   cfg_data
);

  cbs_pkg::dp_cmd_t    cmd;
  cbs_pkg::dp_status_t status;

  // register writes never stall
  assign cfg_ready = 1'b1;

  // sequencer
  cbs_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  // window, weights, mac, dividers and output register
  cbs_datapath u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .status    (status),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule
